// ----- src/bf3m_pkg.sv -----
`default_nettype none

package bf3m_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int SUM_W             = SAMPLE_W + 4;
    localparam int COL_SUM_W         = SAMPLE_W + 2;
    localparam int CFG_WIDTH_W       = 11;
    localparam int CFG_HEIGHT_W      = 13;
    localparam int CFG_DATA_W        = CFG_HEIGHT_W;
    localparam int ROW_W             = 12;
    localparam int HEIGHT_LIMIT      = 4096;
    localparam int MIN_SIZE          = 2;
    localparam int RESET_WIDTH       = 1024;
    localparam int RESET_HEIGHT      = 1024;
    localparam int DEFAULT_MAX_WIDTH = 1024;

    // Reciprocal multiply: floor(n / d) == (n * ceil(2^SHIFT / d)) >> SHIFT
    // holds exactly for every n below 2^SUM_W with d in {4, 6, 9}.
    localparam int RECIP_SHIFT = SUM_W + 4;
    localparam int RECIP_W     = RECIP_SHIFT - 1;
    localparam int RECIP_4     = (2 ** RECIP_SHIFT) / 4;
    localparam int RECIP_6     = (2 ** RECIP_SHIFT + 5) / 6;
    localparam int RECIP_9     = (2 ** RECIP_SHIFT + 8) / 9;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        DIV4 = 2'd0,
        DIV6 = 2'd1,
        DIV9 = 2'd2
    } div_t;

    // One accepted pixel with its position already decoded.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                has_result;
        logic                has_left;
        logic                has_top;
        logic                end_col;
        logic                end_row;
    } item_t;

    // One window sum waiting for its divide.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        div_t             div;
        logic             run_last;
        logic             frame_last;
    } sum_req_t;

    function automatic logic [RECIP_W-1:0] recip(input div_t d);
        logic [RECIP_W-1:0] r;
        case (d)
            DIV4:    r = RECIP_W'(RECIP_4);
            DIV6:    r = RECIP_W'(RECIP_6);
            DIV9:    r = RECIP_W'(RECIP_9);
            default: r = RECIP_W'(RECIP_4);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/bf3m_ram.sv -----
`default_nettype none

module bf3m_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/bf3m_window.sv -----
`default_nettype none

module bf3m_window #(
    parameter int MAX_WIDTH = bf3m_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         take,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] take_addr,
    input  wire bf3m_pkg::item_t              take_item,
    output logic                              ready,
    output logic                              req_valid,
    output bf3m_pkg::sum_req_t                req,
    input  wire logic                         req_ready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int SW = bf3m_pkg::SAMPLE_W;
    localparam int CW = bf3m_pkg::COL_SUM_W;
    localparam int TW = bf3m_pkg::SUM_W;

    typedef enum logic [3:0] {
        KIND_MAIN   = 4'b0001,
        KIND_EDGE   = 4'b0010,
        KIND_LOW    = 4'b0100,
        KIND_CORNER = 4'b1000
    } kind_t;

    logic              clr_reg;
    logic              clr_next;
    logic [AW-1:0]     clr_addr_reg;
    logic              b_valid_reg;
    logic              b_valid_next;
    bf3m_pkg::item_t   b_item_reg;
    logic [AW-1:0]     b_addr_reg;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic              fwd_reg;
    logic [SW-1:0]     fwd_older_reg;
    logic [SW-1:0]     fwd_newer_reg;
    logic [SW-1:0]     p1_reg [3];
    logic [SW-1:0]     p2_reg [3];

    logic [SW-1:0]     older_rd;
    logic [SW-1:0]     newer_rd;
    logic [SW-1:0]     cur [3];
    logic              last;
    logic              retire;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [SW-1:0]     older_wdata;
    logic [SW-1:0]     newer_wdata;
    logic              three_cols;
    logic              three_rows;
    logic [CW-1:0]     left_sum;
    logic [CW-1:0]     mid_sum;
    logic [CW-1:0]     right_sum;

    function automatic logic [CW-1:0] col_sum(input logic [SW-1:0] top_v,
                                              input logic [SW-1:0] mid_v,
                                              input logic [SW-1:0] bot_v,
                                              input logic        use_top);
        logic [CW-1:0] s;
        s = CW'(mid_v) + CW'(bot_v);
        if (use_top)
        begin
            s = s + CW'(top_v);
        end
        return s;
    endfunction

    // Line stores: older holds row y-2, newer holds row y-1.
    bf3m_ram #(.WIDTH(SW), .DEPTH(MAX_WIDTH)) u_older_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (older_wdata),
        .re    (take),
        .raddr (take_addr),
        .rdata (older_rd)
    );

    bf3m_ram #(.WIDTH(SW), .DEPTH(MAX_WIDTH)) u_newer_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (newer_wdata),
        .re    (take),
        .raddr (take_addr),
        .rdata (newer_rd)
    );

    // Column of the current pixel; bypass the store when the item just ahead
    // wrote the same column at the edge this one was read.
    always_comb
    begin
        cur[0] = fwd_reg ? fwd_older_reg : older_rd;
        cur[1] = fwd_reg ? fwd_newer_reg : newer_rd;
        cur[2] = b_item_reg.sample;
    end

    always_comb
    begin
        kind_next = kind_reg;
        last      = 1'b1;
        case (kind_reg)
            KIND_MAIN:
            begin
                if (b_item_reg.end_col)
                begin
                    kind_next = KIND_EDGE;
                    last      = 1'b0;
                end
                else if (b_item_reg.end_row)
                begin
                    kind_next = KIND_LOW;
                    last      = 1'b0;
                end
            end
            KIND_EDGE:
            begin
                if (b_item_reg.end_row)
                begin
                    kind_next = KIND_LOW;
                    last      = 1'b0;
                end
            end
            KIND_LOW:
            begin
                if (b_item_reg.end_col)
                begin
                    kind_next = KIND_CORNER;
                    last      = 1'b0;
                end
            end
            KIND_CORNER:
            begin
                last = 1'b1;
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
    end

    // Window sum for the result in flight.
    always_comb
    begin
        three_cols = (kind_reg inside {KIND_MAIN, KIND_LOW}) && b_item_reg.has_left;
        three_rows = (kind_reg inside {KIND_MAIN, KIND_EDGE}) && b_item_reg.has_top;
        left_sum   = col_sum(p2_reg[0], p2_reg[1], p2_reg[2], three_rows);
        mid_sum    = col_sum(p1_reg[0], p1_reg[1], p1_reg[2], three_rows);
        right_sum  = col_sum(cur[0], cur[1], cur[2], three_rows);

        req.sum = TW'(mid_sum) + TW'(right_sum);
        if (three_cols)
        begin
            req.sum = req.sum + TW'(left_sum);
        end
        if (three_cols && three_rows)
        begin
            req.div = bf3m_pkg::DIV9;
        end
        else if (three_cols || three_rows)
        begin
            req.div = bf3m_pkg::DIV6;
        end
        else
        begin
            req.div = bf3m_pkg::DIV4;
        end
        req.run_last   = last;
        req.frame_last = (kind_reg == KIND_CORNER);
    end

    assign req_valid = b_valid_reg && b_item_reg.has_result;
    assign retire    = b_valid_reg && (!b_item_reg.has_result || (req_ready && last));
    assign ready     = !clr_reg && (!b_valid_reg || retire);

    // Store write: clearing pass first, then one row shift per retired item.
    always_comb
    begin
        ram_we      = clr_reg || retire;
        ram_waddr   = clr_reg ? clr_addr_reg : b_addr_reg;
        older_wdata = clr_reg ? '0 : cur[1];
        newer_wdata = clr_reg ? '0 : cur[2];
    end

    always_comb
    begin
        clr_next = clr_reg;
        if (clr_reg && clr_addr_reg == AW'(MAX_WIDTH - 1))
        begin
            clr_next = 1'b0;
        end
        b_valid_next = b_valid_reg;
        if (take)
        begin
            b_valid_next = 1'b1;
        end
        else if (retire)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            b_valid_reg  <= 1'b0;
            kind_reg     <= KIND_MAIN;
            fwd_reg      <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= '0;
                p2_reg[i] <= '0;
            end
        end
        else
        begin
            clr_reg     <= clr_next;
            b_valid_reg <= b_valid_next;
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (take)
            begin
                kind_reg <= KIND_MAIN;
                fwd_reg  <= b_valid_reg && (take_addr == b_addr_reg);
            end
            else if (req_valid && req_ready && !last)
            begin
                kind_reg <= kind_next;
            end
            if (retire)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p2_reg[i] <= p1_reg[i];
                    p1_reg[i] <= cur[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            b_item_reg    <= take_item;
            b_addr_reg    <= take_addr;
            fwd_older_reg <= cur[1];
            fwd_newer_reg <= cur[2];
        end
    end

    a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !clr_reg)
        else $error("item taken during store clearing");

    a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req.frame_last) |-> req.run_last)
        else $error("frame end result not last of its run");

    a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> b_valid_reg)
        else $error("taken item did not land in window stage");

endmodule

`default_nettype wire

// ----- src/bf3m_mean.sv -----
`default_nettype none

module bf3m_mean (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire bf3m_pkg::sum_req_t            req,
    output logic                               req_ready,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [bf3m_pkg::SAMPLE_W-1:0]      smoothed,
    output logic                               run_last,
    output logic                               frame_last
);

    localparam int PW = bf3m_pkg::SUM_W + bf3m_pkg::RECIP_W;

    logic                         c_valid_reg;
    bf3m_pkg::sum_req_t           c_req_reg;
    logic                         out_valid_reg;
    logic [bf3m_pkg::SAMPLE_W-1:0] smoothed_reg;
    logic                         run_last_reg;
    logic                         frame_last_reg;
    logic                         out_free;
    logic                         c_move;
    logic [PW-1:0]                product;

    assign out_free  = !out_valid_reg || !out_stall;
    assign c_move    = c_valid_reg && out_free;
    assign req_ready = !c_valid_reg || out_free;

    // Constant divide by 4, 6 or 9 through the reciprocal.
    assign product = PW'(c_req_reg.sum) * PW'(bf3m_pkg::recip(c_req_reg.div));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                c_valid_reg <= req_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            c_req_reg <= req;
        end
        if (c_move)
        begin
            smoothed_reg   <= product[bf3m_pkg::RECIP_SHIFT +: bf3m_pkg::SAMPLE_W];
            run_last_reg   <= c_req_reg.run_last;
            frame_last_reg <= c_req_reg.frame_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign smoothed   = smoothed_reg;
    assign run_last   = run_last_reg;
    assign frame_last = frame_last_reg;

    a_sum_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !out_free) |=> c_valid_reg)
        else $error("sum stage dropped a held result");

endmodule

`default_nettype wire

// ----- src/box_filter_3x3_mean.sv -----
//  Channel  Direction  Handshake              Payload
//  -------  ---------  ---------------------  ----------------------------------
//  in       to block   in_valid / in_stall    sample[15:0], frame_start
//  out      from block out_valid / out_stall  smoothed[15:0], run_last, frame_last
//  cfg      to block   cfg_valid / cfg_ready  cfg_index (0 width, 1 height), cfg_data
//
//  One pixel is taken per cycle, unless out_stall holds the result path back,
//  while each pixel causes at most one result; a pixel that causes two to four
//  results holds the input until its last result is taken by the single result
//  path (one window sum and one divide per cycle while out_stall is low).
//  A pixel's first result passes the window stage, the divide stage and then
//  the output register. After reset the line stores are cleared at all MAX_WIDTH
//  addresses with in_stall high; configuration writes are taken at any time.
//  out_stall backs up through the sum stage to in_stall combinationally.
`default_nettype none

module box_filter_3x3_mean #(
    parameter int MAX_WIDTH = bf3m_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [bf3m_pkg::SAMPLE_W-1:0]     sample,
    input  wire logic                              frame_start,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [bf3m_pkg::SAMPLE_W-1:0]          smoothed,
    output logic                                   run_last,
    output logic                                   frame_last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire bf3m_pkg::cfg_index_t              cfg_index,
    input  wire logic [bf3m_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    // Compare width for column positions against the clamped width.
    localparam int XW = ($clog2(MAX_WIDTH + 1) > bf3m_pkg::CFG_WIDTH_W)
                        ? $clog2(MAX_WIDTH + 1) : bf3m_pkg::CFG_WIDTH_W;
    localparam int HW = bf3m_pkg::CFG_HEIGHT_W;
    localparam int RW = bf3m_pkg::ROW_W;
    localparam int RESET_W = (bf3m_pkg::RESET_WIDTH > MAX_WIDTH)
                             ? MAX_WIDTH : bf3m_pkg::RESET_WIDTH;

    // Geometry is stored already clamped to its legal range.
    logic [XW-1:0]          width_reg;
    logic [XW-1:0]          width_next;
    logic [HW-1:0]          height_reg;
    logic [HW-1:0]          height_next;
    logic [AW-1:0]          col_reg;
    logic [AW-1:0]          col_next;
    logic [RW-1:0]          row_reg;
    logic [RW-1:0]          row_next;

    logic                   take;
    logic                   win_ready;
    logic [AW-1:0]          x;
    logic [RW-1:0]          y;
    logic [XW-1:0]          x_inc;
    logic [HW-1:0]          y_inc;
    bf3m_pkg::item_t        item;
    logic                   req_valid;
    logic                   req_ready;
    bf3m_pkg::sum_req_t     req;
    logic [XW-1:0]          cfg_w;
    logic [HW-1:0]          cfg_h;

    assign cfg_ready = 1'b1;
    assign in_stall  = !win_ready;
    assign take      = in_valid && win_ready;

    // Clamp register writes; the upper data bits are ignored for the width.
    always_comb
    begin
        cfg_w = XW'(cfg_data[bf3m_pkg::CFG_WIDTH_W-1:0]);
        cfg_h = cfg_data;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bf3m_pkg::CFG_IMAGE_WIDTH:
                begin
                    if (cfg_w < XW'(bf3m_pkg::MIN_SIZE))
                    begin
                        width_next = XW'(bf3m_pkg::MIN_SIZE);
                    end
                    else if (cfg_w > XW'(MAX_WIDTH))
                    begin
                        width_next = XW'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_next = cfg_w;
                    end
                end
                bf3m_pkg::CFG_IMAGE_HEIGHT:
                begin
                    if (cfg_h < HW'(bf3m_pkg::MIN_SIZE))
                    begin
                        height_next = HW'(bf3m_pkg::MIN_SIZE);
                    end
                    else if (cfg_h > HW'(bf3m_pkg::HEIGHT_LIMIT))
                    begin
                        height_next = HW'(bf3m_pkg::HEIGHT_LIMIT);
                    end
                    else
                    begin
                        height_next = cfg_h;
                    end
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    // Position of the arriving pixel; restart a counter on frame start or
    // when it lies beyond the current geometry.
    always_comb
    begin
        x = col_reg;
        y = row_reg;
        if (frame_start || XW'(col_reg) >= width_reg)
        begin
            x = '0;
        end
        if (frame_start || HW'(row_reg) >= height_reg)
        begin
            y = '0;
        end
        x_inc = XW'(x) + XW'(1);
        y_inc = HW'(y) + HW'(1);

        item.sample     = sample;
        item.has_result = (x != '0) && (y != '0);
        item.has_left   = XW'(x) >= XW'(2);
        item.has_top    = HW'(y) >= HW'(2);
        item.end_col    = x_inc == width_reg;
        item.end_row    = y_inc == height_reg;

        // Advance raster position, wrapping at row and frame end.
        col_next = col_reg;
        row_next = row_reg;
        if (take)
        begin
            col_next = AW'(x_inc);
            row_next = y;
            if (x_inc >= width_reg)
            begin
                col_next = '0;
                row_next = (y_inc >= height_reg) ? '0 : RW'(y_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= XW'(RESET_W);
            height_reg <= HW'(bf3m_pkg::RESET_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // Line stores, 3x3 window and result sequencing.
    bf3m_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .take_addr (x),
        .take_item (item),
        .ready     (win_ready),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready)
    );

    // Divide stage and output register.
    bf3m_mean u_mean (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req        (req),
        .req_ready  (req_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .smoothed   (smoothed),
        .run_last   (run_last),
        .frame_last (frame_last)
    );

    a_position_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (XW'(col_reg) < width_reg) && (HW'(row_reg) < height_reg))
        else $error("raster position left the frame after a transfer");

endmodule

`default_nettype wire
